[rtl/sta_pkg.sv]
// Shared types and constants for the station table with aging.
package sta_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = IDX_W + 1;
  localparam int SLOTS = 64;
  localparam int SLOT_W = 6;
  localparam int MAC_W = 48;
  localparam int TICK_W = 32;

  localparam logic [1:0] CAT_OPEN = 2'd0;
  localparam logic [1:0] CAT_WEP = 2'd1;
  localparam logic [1:0] CAT_WPA = 2'd2;

  localparam logic OP_SIGHT = 1'b0;
  localparam logic OP_SWEEP = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_SLOT  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  // Information stored per entry in the entry memory.
  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [TICK_W-1:0] seen;
    logic [7:0]        chan;
    logic [7:0]        sig;
    logic [1:0]        prot;
    logic [1:0]        cls;
    logic [SLOT_W-1:0] slot;
  } entry_t;

endpackage

[rtl/sta_entry_ram.sv]
// Entry memory: one write port, one registered read port.
module sta_entry_ram (
  input  logic                            clk,
  input  logic                            we,
  input  logic [sta_pkg::IDX_W-1:0]       waddr,
  input  sta_pkg::entry_t                 wdata,
  input  logic [sta_pkg::IDX_W-1:0]       raddr,
  output sta_pkg::entry_t                 rdata
);

  sta_pkg::entry_t mem [sta_pkg::ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/station_table_with_aging.sv]
// Top level of the station table with aging.
// The block holds up to 64 stations keyed by 48-bit MAC address. Raise start
// with a word on the input ports while busy is low; exactly one result word
// follows on the result ports, marked by done for a single cycle, and the
// receiver cannot stall it. Every item walks all entries once through one
// registered read port of the entry memory and one shared compare unit,
// and a new station then also waits while the slot map is searched one
// bit a cycle. busy is high from acceptance and is low again in the
// cycle of done. The age limit register is
// written through cfg_valid/cfg_ready; write it only while the block is idle.
module station_table_with_aging (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [47:0] station_mac,
  input  logic [7:0]  radio_channel,
  input  logic [7:0]  signal_level,
  input  logic        uses_wpa,
  input  logic        uses_wep,
  input  logic [31:0] now_tick,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic        was_known,
  output logic [1:0]  category,
  output logic [5:0]  slot_index,
  output logic        table_full,
  output logic [6:0]  removed_count,
  output logic [6:0]  station_count
);

  localparam int IW = sta_pkg::IDX_W;
  localparam int CW = sta_pkg::CNT_W;

  sta_pkg::state_t state;

  logic [31:0] age_limit;
  // Captured input word.
  logic        r_op;
  logic [47:0] r_mac;
  logic [7:0]  r_chan;
  logic [7:0]  r_sig;
  logic        r_wpa;
  logic        r_wep;
  logic [31:0] r_now;
  logic [1:0]  r_cat;

  logic [sta_pkg::ENTRIES-1:0] entry_valid;
  logic [sta_pkg::SLOTS-1:0]   slot_busy [3];
  logic [CW-1:0]               held_count;

  // Scan counters: rcnt drives the read address, ccnt is rcnt registered and so lines up with the read data.
  logic [CW-1:0] rcnt;
  logic [CW-1:0] ccnt;
  logic          cvalid;
  logic          hit;
  logic [IW-1:0] free_idx;
  logic          free_found;
  logic [6:0]    scnt;
  logic [5:0]    free_slot;
  logic          slot_found;
  logic [6:0]    removed;

  logic          we;
  logic [IW-1:0] waddr;
  sta_pkg::entry_t wdata;
  sta_pkg::entry_t rdata;

  sta_entry_ram u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rcnt[IW-1:0]),
    .rdata (rdata)
  );

  assign busy = (state != sta_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // The shared compare unit looks at the one entry read out this cycle.
  logic [IW-1:0] cidx;
  logic          cur_valid;
  logic          mac_eq;
  logic          aged;
  assign cidx = ccnt[IW-1:0];
  assign cur_valid = cvalid && entry_valid[cidx];
  assign mac_eq = (rdata.mac == r_mac);
  assign aged = ((r_now - rdata.seen) > age_limit) && (age_limit != 32'd0);

  logic [1:0] hit_cls_q;
  logic [5:0] hit_slot_q;

  always_comb begin
    we = 1'b0;
    waddr = cidx;
    wdata.mac = r_mac;
    wdata.seen = r_now;
    wdata.chan = r_chan;
    wdata.sig = r_sig;
    wdata.prot = {r_wpa, r_wep};
    wdata.cls = rdata.cls;
    wdata.slot = rdata.slot;
    if (state == sta_pkg::ST_SCAN && r_op == sta_pkg::OP_SIGHT && !hit &&
        cur_valid && mac_eq) begin
      we = 1'b1;
    end else if (state == sta_pkg::ST_WRITE) begin
      we = 1'b1;
      waddr = free_idx;
      wdata.cls = r_cat;
      wdata.slot = free_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age_limit <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      age_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sta_pkg::ST_IDLE;
      entry_valid <= '0;
      for (int c = 0; c < 3; c++) slot_busy[c] <= '0;
      held_count <= '0;
      done <= 1'b0;
      rcnt <= '0;
      ccnt <= '0;
      cvalid <= 1'b0;
      hit <= 1'b0;
      free_found <= 1'b0;
      slot_found <= 1'b0;
      removed <= '0;
      scnt <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        sta_pkg::ST_IDLE: begin
          if (start) begin
            r_op <= op;
            r_mac <= station_mac;
            r_chan <= radio_channel;
            r_sig <= signal_level;
            r_wpa <= uses_wpa;
            r_wep <= uses_wep;
            r_now <= now_tick;
            r_cat <= uses_wpa ? sta_pkg::CAT_WPA :
                     (uses_wep ? sta_pkg::CAT_WEP : sta_pkg::CAT_OPEN);
            rcnt <= '0;
            cvalid <= 1'b0;
            hit <= 1'b0;
            free_found <= 1'b0;
            slot_found <= 1'b0;
            removed <= '0;
            scnt <= '0;
            state <= sta_pkg::ST_SCAN;
          end
        end
        sta_pkg::ST_SCAN: begin
          // When the last entry is checked, rcnt already sits at ENTRIES,
          // so cvalid drops here on its own.
          if (rcnt != CW'(sta_pkg::ENTRIES)) rcnt <= rcnt + 1'b1;
          ccnt <= rcnt;
          cvalid <= (rcnt != CW'(sta_pkg::ENTRIES));
          if (cvalid) begin
            if (r_op == sta_pkg::OP_SWEEP) begin
              if (cur_valid && aged) begin
                entry_valid[cidx] <= 1'b0;
                if (rdata.cls != 2'd3) slot_busy[rdata.cls][rdata.slot] <= 1'b0;
                held_count <= held_count - 1'b1;
                removed <= removed + 1'b1;
              end
            end else if (!hit) begin
              if (cur_valid && mac_eq) begin
                hit <= 1'b1;
                hit_cls_q <= rdata.cls;
                hit_slot_q <= rdata.slot;
              end else if (!entry_valid[cidx] && !free_found) begin
                free_found <= 1'b1;
                free_idx <= cidx;
              end
            end
          end
          if (cvalid && ccnt == CW'(sta_pkg::ENTRIES - 1)) begin
            if (r_op == sta_pkg::OP_SIGHT && !hit && !(cur_valid && mac_eq))
              state <= sta_pkg::ST_SLOT;
            else
              state <= sta_pkg::ST_DONE;
          end
        end
        sta_pkg::ST_SLOT: begin
          // One slot bit per cycle, lowest first.
          if (scnt == 7'(sta_pkg::SLOTS) || !free_found) begin
            state <= sta_pkg::ST_DONE;
          end else if (!slot_busy[r_cat][scnt[5:0]]) begin
            slot_found <= 1'b1;
            free_slot <= scnt[5:0];
            state <= sta_pkg::ST_WRITE;
          end else begin
            scnt <= scnt + 1'b1;
          end
        end
        sta_pkg::ST_WRITE: begin
          entry_valid[free_idx] <= 1'b1;
          slot_busy[r_cat][free_slot] <= 1'b1;
          held_count <= held_count + 1'b1;
          state <= sta_pkg::ST_DONE;
        end
        sta_pkg::ST_DONE: begin
          done <= 1'b1;
          state <= sta_pkg::ST_IDLE;
        end
        default: state <= sta_pkg::ST_IDLE;
      endcase
    end
  end

  // Result word, valid in the cycle that done is high.
  always_comb begin
    was_known = 1'b0;
    category = 2'd0;
    slot_index = 6'd0;
    table_full = 1'b0;
    removed_count = 7'd0;
    station_count = 7'(held_count);
    if (r_op == sta_pkg::OP_SWEEP) begin
      removed_count = removed;
    end else if (hit) begin
      was_known = 1'b1;
      category = hit_cls_q;
      slot_index = hit_slot_q;
    end else begin
      category = r_cat;
      slot_index = slot_found ? free_slot : 6'd0;
      table_full = !slot_found;
    end
  end

  a_done_one: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");
  a_busy_done: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while still busy");
  a_count: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(sta_pkg::ENTRIES))
    else $error("held count beyond capacity");
  a_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

endmodule
